// ===== design/i2da_pkg.sv =====
// Shared types and constants for the 64-bit integer to decimal text converter.
package i2da_pkg;

	localparam int VALUE_W    = 64;
	localparam int NUM_DIGITS = 20;
	localparam int CHAR_W     = 6;
	localparam int DIGIT_W    = 4;

	localparam logic [CHAR_W-1:0] DIGIT_BASE_CODE = 6'd48;
	localparam logic [CHAR_W-1:0] MINUS_CODE      = 6'd45;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_DABBLE,
		CELL_SHIFT
	} cell_mode_t;

	// what a cell receives from the neighbor below it
	typedef struct packed {
		logic               bit_in;
		logic [DIGIT_W-1:0] digit_in;
	} cell_in_t;

	// what a cell hands to the neighbor above it
	typedef struct packed {
		logic               carry;
		logic [DIGIT_W-1:0] digit;
	} cell_out_t;

endpackage

// ===== design/i2da_cell.sv =====
// One BCD digit cell of the shift-and-add-3 chain.
module i2da_cell
	import i2da_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_mode_t mode,
	input  cell_in_t   from_below,
	output cell_out_t  to_above
);

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] adj;

	// add 3 before the shift so the doubled digit carries at ten
	always_comb begin
		if (digit_q >= DIGIT_W'(5)) begin
			adj = digit_q + DIGIT_W'(3);
		end else begin
			adj = digit_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else begin
			unique case (mode)
				CELL_HOLD:   digit_q <= digit_q;
				CELL_CLEAR:  digit_q <= '0;
				CELL_DABBLE: digit_q <= {adj[DIGIT_W-2:0], from_below.bit_in};
				CELL_SHIFT:  digit_q <= from_below.digit_in;
				default:     digit_q <= digit_q;
			endcase
		end
	end

	assign to_above.carry = adj[DIGIT_W-1];
	assign to_above.digit = digit_q;

endmodule

// ===== design/int64_to_decimal_ascii.sv =====
// Top level: signed 64-bit integer to decimal ASCII text, one character per beat.
// Pulse start while busy is low to load value. The magnitude is shifted, one bit a
// cycle, into a row of twenty BCD digit cells; leading zero digits are then shifted
// out of the top cell, one a cycle, and the text follows one character a cycle: a
// minus sign first for a negative value, then the digits, most significant first,
// with is_last on the final one. Each character is on text_char for exactly one
// cycle with strobe high; the receiver must take it then. A new value is taken only
// in the idle state, once busy is low, so one conversion finishes before the next
// begins. The most negative value gives "-9223372036854775808".
module int64_to_decimal_ascii
	import i2da_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [63:0]  value,
	output logic                strobe,
	output logic [CHAR_W-1:0]   text_char,
	output logic                is_last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SKIP = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	localparam int BIT_CNT_W = $clog2(VALUE_W);
	localparam int REM_W     = $clog2(NUM_DIGITS + 1);

	logic [1:0]           state_q;
	logic [VALUE_W-1:0]   mag_q;
	logic                 neg_q;
	logic [BIT_CNT_W-1:0] bit_cnt_q;
	logic [REM_W-1:0]     rem_q;
	logic                 strobe_q;
	logic [CHAR_W-1:0]    char_q;
	logic                 last_q;

	cell_mode_t           mode;
	cell_in_t             cin  [NUM_DIGITS];
	cell_out_t            cout [NUM_DIGITS];
	logic [DIGIT_W-1:0]   top_digit;
	logic                 accept;

	assign accept    = start && (state_q == ST_IDLE);
	assign top_digit = cout[NUM_DIGITS-1].digit;

	always_comb begin
		unique case (state_q)
			ST_IDLE: mode = accept ? CELL_CLEAR : CELL_HOLD;
			ST_CONV: mode = CELL_DABBLE;
			ST_SKIP: mode = (top_digit == '0 && rem_q > REM_W'(1)) ? CELL_SHIFT : CELL_HOLD;
			ST_EMIT: mode = CELL_SHIFT;
			default: mode = CELL_HOLD;
		endcase
	end

	assign cin[0].bit_in   = mag_q[VALUE_W-1];
	assign cin[0].digit_in = '0;

	for (genvar i = 1; i < NUM_DIGITS; i++) begin : g_link
		assign cin[i].bit_in   = cout[i-1].carry;
		assign cin[i].digit_in = cout[i-1].digit;
	end

	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		i2da_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.mode       (mode),
			.from_below (cin[i]),
			.to_above   (cout[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			rem_q     <= '0;
			strobe_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					strobe_q <= 1'b0;
					if (accept) begin
						state_q   <= ST_CONV;
						bit_cnt_q <= '0;
						rem_q     <= REM_W'(NUM_DIGITS);
					end
				end
				ST_CONV: begin
					strobe_q  <= 1'b0;
					bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
					if (bit_cnt_q == BIT_CNT_W'(VALUE_W - 1)) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (top_digit == '0 && rem_q > REM_W'(1)) begin
						strobe_q <= 1'b0;
						rem_q    <= rem_q - REM_W'(1);
					end else begin
						// sign beat goes out while moving on to the digits
						state_q  <= ST_EMIT;
						strobe_q <= neg_q;
					end
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					rem_q    <= rem_q - REM_W'(1);
					if (rem_q == REM_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					strobe_q <= 1'b0;
					state_q  <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= value[VALUE_W-1];
			mag_q <= value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value)) : VALUE_W'(value);
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
		end
		if (state_q == ST_SKIP) begin
			char_q <= MINUS_CODE;
			last_q <= 1'b0;
		end else begin
			char_q <= DIGIT_BASE_CODE + CHAR_W'(top_digit);
			last_q <= (rem_q == REM_W'(1));
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign strobe    = strobe_q;
	assign text_char = char_q;
	assign is_last   = strobe_q && last_q;

`ifndef NO_ASSERTIONS
	a_strobe_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ($past(state_q) == ST_SKIP || $past(state_q) == ST_EMIT))
		else $error("strobe without a conversion in progress");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		is_last |-> (state_q == ST_IDLE || state_q == ST_CONV))
		else $error("last beat while digits remain");

	a_conv_full_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) |-> (rem_q == REM_W'(NUM_DIGITS)))
		else $error("digit count disturbed during conversion");

	a_top_digit_bcd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SKIP || state_q == ST_EMIT) |-> (top_digit <= DIGIT_W'(9)))
		else $error("top cell holds a non-decimal digit");
`endif

endmodule

// ===== tb/int64_to_decimal_ascii_test.sv =====
// Testbench for the signed 64-bit integer to decimal ASCII text converter.
`timescale 1ns / 100ps

module int64_to_decimal_ascii_test
	import i2da_pkg::*;
();

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 30;
	localparam int RADIX = 10;
	localparam int RANDOM_PER_PHASE = 120;

	typedef struct {
		logic [CHAR_W-1:0] code;
		logic              last;
	} text_beat_t;

	// Spells each accepted value into its expected characters and checks the output
	// beats against them in order.
	class decimal_text_tracker;
		text_beat_t pending_chars[$];
		int mismatches;
		int values_seen;
		int negatives_seen;
		int chars_checked;
		int longest_text;

		function new();
			mismatches = 0;
			values_seen = 0;
			negatives_seen = 0;
			chars_checked = 0;
			longest_text = 0;
		endfunction

		function void note_value(logic [VALUE_W-1:0] num);
			logic [VALUE_W-1:0] mag;
			logic [DIGIT_W-1:0] digits[$];
			text_beat_t beat;
			int n;
			mag = num[VALUE_W-1] ? (~num + 1'b1) : num;
			n = 0;
			// collect digits least significant first; zero still gives one digit
			do begin
				digits.push_back(DIGIT_W'(mag % RADIX));
				mag = mag / RADIX;
			end while (mag != 0);
			if (num[VALUE_W-1]) begin
				beat.code = MINUS_CODE;
				beat.last = 1'b0;
				pending_chars.push_back(beat);
				negatives_seen++;
				n++;
			end
			for (int k = digits.size() - 1; k >= 0; k--) begin
				beat.code = DIGIT_BASE_CODE + CHAR_W'(digits[k]);
				beat.last = (k == 0);
				pending_chars.push_back(beat);
				n++;
			end
			values_seen++;
			if (n > longest_text)
				longest_text = n;
		endfunction

		function void check_char(logic [CHAR_W-1:0] code, logic last);
			text_beat_t want;
			chars_checked++;
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected beat text_char=%0d is_last=%0b",
					$time, code, last);
				mismatches++;
				return;
			end
			want = pending_chars.pop_front();
			if (code !== want.code) begin
				$display("%0t: text_char mismatch: expected %0d, actual %0d",
					$time, want.code, code);
				mismatches++;
			end
			if (last !== want.last) begin
				$display("%0t: is_last mismatch: expected %0b, actual %0b",
					$time, want.last, last);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return pending_chars.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic signed [63:0]   value;
	logic                 strobe;
	logic [CHAR_W-1:0]    text_char;
	logic                 is_last;

	decimal_text_tracker tracker;
	int cycle_count;
	int send_idle_pct;

	int64_to_decimal_ascii dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.strobe    (strobe),
		.text_char (text_char),
		.is_last   (is_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles with %0d characters outstanding",
			cycle_count, tracker.outstanding());
		$display("FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && strobe === 1'b1)
			tracker.check_char(text_char, is_last);
	end

	// Idle a random number of cycles, then present one value and hold it until taken.
	task automatic send_value(logic [VALUE_W-1:0] num);
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			value <= {$urandom, $urandom};
			@(negedge clk);
		end
		start <= 1'b1;
		value <= num;
		do
			@(posedge clk);
		while (busy);
		tracker.note_value(num);
		@(negedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] scale;
		logic [VALUE_W-1:0] mag;
		int ndig;
		scale = 1;
		mag = 0;
		case ($urandom_range(3))
			0: mag = {$urandom, $urandom};
			1: begin
				ndig = $urandom_range(19, 1);
				for (int i = 0; i < ndig; i++)
					scale = scale * RADIX;
				mag = {$urandom, $urandom} % scale;
			end
			2: begin
				ndig = $urandom_range(19, 0);
				for (int i = 0; i < ndig; i++)
					scale = scale * RADIX;
				mag = scale - $urandom_range(1);
			end
			default: mag = $urandom_range(999);
		endcase
		return $urandom_range(1) ? (~mag + 1'b1) : mag;
	endfunction

	task automatic run_random(int count);
		for (int i = 0; i < count; i++)
			send_value(pick_value());
	endtask

	initial begin
		logic [VALUE_W-1:0] directed[$];
		tracker = new();
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		send_idle_pct = 34;
		directed = '{
			64'd0, 64'd1, -64'sd1, 64'd9, 64'd10, -64'sd10, 64'd99, 64'd100,
			64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
			64'h8000_0000_0000_0001,
			64'd1000000000000000000, 64'd999999999999999999,
			-64'sd999999999999999999, -64'sd1000000000000000000,
			64'd1234567890, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
			64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF
		};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_value(directed[i]);
		run_random(RANDOM_PER_PHASE);
		send_idle_pct = 81;
		run_random(RANDOM_PER_PHASE);
		send_idle_pct = 0;
		run_random(RANDOM_PER_PHASE);
		start <= 1'b0;

		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d values (%0d negative) into %0d characters",
			tracker.values_seen, tracker.negatives_seen, tracker.chars_checked);
		$display("Longest text was %0d characters; %0d mismatches",
			tracker.longest_text, tracker.mismatches);
		if (tracker.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
